FILE: rtl/flvd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flvd_pkg
// Shared types and constants for the FLV tag deframer: parse phases,
// record kinds, the record carried between parser and result queue.
// ----------------------------------------------------------------------------
package flvd_pkg;

  // parse phase of the byte stream
  typedef enum logic [2:0] {
    PH_FILE_HDR = 3'd0,
    PH_SKIP     = 3'd1,
    PH_PREV     = 3'd2,
    PH_TAG_HDR  = 3'd3,
    PH_PAYLOAD  = 3'd4
  } phase_e;

  // kind of result record
  typedef enum logic [1:0] {
    KIND_FILE_HDR = 2'd0,
    KIND_TAG_HDR  = 2'd1,
    KIND_PAYLOAD  = 2'd2
  } rec_kind_e;

  // one result record, unused fields held at zero
  typedef struct packed {
    rec_kind_e   kind;
    logic [7:0]  version;
    logic        has_audio;
    logic        has_video;
    logic [31:0] header_length;
    logic [7:0]  tag_type;
    logic [23:0] data_size;
    logic [31:0] timestamp;
    logic [23:0] stream_id;
    logic [7:0]  payload_byte;
    logic        last_of_tag;
  } rec_t;

  // byte positions and lengths in the container
  localparam logic [31:0] FileHdrLen    = 32'd9;
  localparam logic [31:0] FileHdrLast   = 32'd8;
  localparam logic [31:0] FileVerPos    = 32'd3;
  localparam logic [31:0] FileFlagPos   = 32'd4;
  localparam logic [31:0] FileLenPos    = 32'd5;
  localparam logic [31:0] PrevSizeLast  = 32'd3;
  localparam logic [31:0] TagTypePos    = 32'd0;
  localparam logic [31:0] TagSizeLast   = 32'd3;
  localparam logic [31:0] TagTimeLast   = 32'd6;
  localparam logic [31:0] TagExtPos     = 32'd7;
  localparam logic [31:0] TagHdrLast    = 32'd10;

  // audio flag bit and video flag bit of header byte 4
  localparam int unsigned AudioBit = 2;
  localparam int unsigned VideoBit = 0;

  // result queue geometry
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

endpackage

FILE: rtl/flv_tag_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flv_tag_deframer
// Byte-serial FLV container deframer: file header record, tag header
// records and payload bytes marked with the end of each tag.
// ----------------------------------------------------------------------------
// output: with the record queue empty, a byte that yields a record shows it
//   on the result ports right after the edge that accepts the byte
// throughput: one byte per cycle while not full; full is high while the
//   two-entry queue holds two records, which only happens once pops stall
// reset: asynchronous, clears the parser to the file header phase and
//   empties the record queue
module flv_tag_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  record_kind_o,
  output logic [7:0]  version_o,
  output logic        has_audio_o,
  output logic        has_video_o,
  output logic [31:0] header_length_o,
  output logic [7:0]  tag_type_o,
  output logic [23:0] data_size_o,
  output logic [31:0] timestamp_o,
  output logic [23:0] stream_id_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_of_tag_o
);

  logic           beat;
  logic           rec_valid;
  flvd_pkg::rec_t rec_in;
  flvd_pkg::rec_t rec_out;

  // input beat accepted
  assign beat = push && !full;

  // front: parse and build records
  flvd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .byte_i      (data_byte_i),
    .rec_valid_o (rec_valid),
    .rec_o       (rec_in)
  );

  // back: record queue towards the result side
  flvd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_valid),
    .rec_i   (rec_in),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .rec_o   (rec_out)
  );

  // result fields
  assign record_kind_o   = rec_out.kind;
  assign version_o       = rec_out.version;
  assign has_audio_o     = rec_out.has_audio;
  assign has_video_o     = rec_out.has_video;
  assign header_length_o = rec_out.header_length;
  assign tag_type_o      = rec_out.tag_type;
  assign data_size_o     = rec_out.data_size;
  assign timestamp_o     = rec_out.timestamp;
  assign stream_id_o     = rec_out.stream_id;
  assign payload_byte_o  = rec_out.payload_byte;
  assign last_of_tag_o   = rec_out.last_of_tag;

endmodule

FILE: rtl/flvd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flvd_front
// Byte parser: tracks the container phase, gathers header fields and builds
// one record for each byte that completes a header or carries payload.
// ----------------------------------------------------------------------------
module flvd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             beat_i,
  input  logic [7:0]       byte_i,
  output logic             rec_valid_o,
  output flvd_pkg::rec_t   rec_o
);

  flvd_pkg::phase_e phase_q, phase_d;
  logic [31:0] count_q, count_d;
  logic [31:0] shift_q, shift_d;
  logic [7:0]  version_q, version_d;
  logic        audio_q, audio_d;
  logic        video_q, video_d;
  logic [7:0]  type_q, type_d;
  logic [23:0] size_q, size_d;
  logic [23:0] time_q, time_d;
  logic [7:0]  ext_q, ext_d;

  logic [31:0] count_dec;
  logic [31:0] hdr_len;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= flvd_pkg::PH_FILE_HDR;
      count_q <= '0;
      shift_q <= '0;
      version_q <= '0;
      audio_q <= 1'b0;
      video_q <= 1'b0;
      type_q <= '0;
      size_q <= '0;
      time_q <= '0;
      ext_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      shift_q <= shift_d;
      version_q <= version_d;
      audio_q <= audio_d;
      video_q <= video_d;
      type_q <= type_d;
      size_q <= size_d;
      time_q <= time_d;
      ext_q <= ext_d;
    end
  end

  // saturating down count for skip and payload regions
  assign count_dec = (count_q != '0) ? (count_q - 32'd1) : count_q;
  // header length completes with the current beat
  assign hdr_len = {shift_q[23:0], byte_i};

  // phase decode and record build
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    shift_d = shift_q;
    version_d = version_q;
    audio_d = audio_q;
    video_d = video_q;
    type_d = type_q;
    size_d = size_q;
    time_d = time_q;
    ext_d = ext_q;
    rec_valid_o = 1'b0;
    rec_o = '0;
    if (beat_i) begin
      case (phase_q)
        flvd_pkg::PH_FILE_HDR: begin
          if (count_q == flvd_pkg::FileVerPos) begin
            version_d = byte_i;
          end else if (count_q == flvd_pkg::FileFlagPos) begin
            audio_d = byte_i[flvd_pkg::AudioBit];
            video_d = byte_i[flvd_pkg::VideoBit];
          end else if (count_q >= flvd_pkg::FileLenPos) begin
            shift_d = hdr_len;
          end
          if (count_q < flvd_pkg::FileHdrLast) begin
            count_d = count_q + 32'd1;
          end else begin
            rec_valid_o = 1'b1;
            rec_o.kind = flvd_pkg::KIND_FILE_HDR;
            rec_o.version = version_q;
            rec_o.has_audio = audio_q;
            rec_o.has_video = video_q;
            rec_o.header_length = hdr_len;
            shift_d = '0;
            if (hdr_len > flvd_pkg::FileHdrLen) begin
              count_d = hdr_len - flvd_pkg::FileHdrLen;
              phase_d = flvd_pkg::PH_SKIP;
            end else begin
              count_d = '0;
              phase_d = flvd_pkg::PH_PREV;
            end
          end
        end
        flvd_pkg::PH_SKIP: begin
          count_d = count_dec;
          if (count_dec == '0) phase_d = flvd_pkg::PH_PREV;
        end
        flvd_pkg::PH_PREV: begin
          if (count_q < flvd_pkg::PrevSizeLast) begin
            count_d = count_q + 32'd1;
          end else begin
            count_d = '0;
            shift_d = '0;
            phase_d = flvd_pkg::PH_TAG_HDR;
          end
        end
        flvd_pkg::PH_TAG_HDR: begin
          if (count_q == flvd_pkg::TagTypePos) begin
            type_d = byte_i;
          end else if (count_q <= flvd_pkg::TagSizeLast) begin
            size_d = {size_q[15:0], byte_i};
          end else if (count_q <= flvd_pkg::TagTimeLast) begin
            time_d = {time_q[15:0], byte_i};
          end else if (count_q == flvd_pkg::TagExtPos) begin
            ext_d = byte_i;
          end else begin
            shift_d = {8'd0, shift_q[15:0], byte_i};
          end
          if (count_q < flvd_pkg::TagHdrLast) begin
            count_d = count_q + 32'd1;
          end else begin
            rec_valid_o = 1'b1;
            rec_o.kind = flvd_pkg::KIND_TAG_HDR;
            rec_o.tag_type = type_q;
            rec_o.data_size = size_q;
            rec_o.timestamp = {ext_q, time_q};
            rec_o.stream_id = {shift_q[15:0], byte_i};
            shift_d = '0;
            if (size_q == '0) begin
              rec_o.last_of_tag = 1'b1;
              count_d = '0;
              phase_d = flvd_pkg::PH_PREV;
            end else begin
              count_d = {8'd0, size_q};
              phase_d = flvd_pkg::PH_PAYLOAD;
            end
          end
        end
        flvd_pkg::PH_PAYLOAD: begin
          rec_valid_o = 1'b1;
          rec_o.kind = flvd_pkg::KIND_PAYLOAD;
          rec_o.payload_byte = byte_i;
          count_d = count_dec;
          if (count_dec == '0) begin
            rec_o.last_of_tag = 1'b1;
            phase_d = flvd_pkg::PH_PREV;
          end
        end
        default: begin
          count_d = '0;
          phase_d = flvd_pkg::PH_PREV;
        end
      endcase
    end
  end

  // records only come out of an accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_o |-> beat_i)
    else $error("record without an accepted beat");

  // a file header record only ends the file header phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_valid_o && rec_o.kind == flvd_pkg::KIND_FILE_HDR)
      |=> phase_q != flvd_pkg::PH_FILE_HDR)
    else $error("file header record left parser in file header phase");

  // the payload region always has bytes left to come
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == flvd_pkg::PH_PAYLOAD |-> count_q != '0)
    else $error("payload phase with zero bytes remaining");

endmodule

FILE: rtl/flvd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flvd_queue
// Short record queue between the parser and the result side; it holds up to
// two records while the result side stalls, and full then holds the input.
// ----------------------------------------------------------------------------
module flvd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  flvd_pkg::rec_t  rec_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output flvd_pkg::rec_t  rec_o
);

  flvd_pkg::rec_t mem_q [flvd_pkg::QDepth];
  logic [flvd_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [flvd_pkg::QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [flvd_pkg::QCntW-1:0] count_q, count_d;
  logic do_pop;

  assign full_o  = (count_q == flvd_pkg::QCntW'(flvd_pkg::QDepth));
  assign empty_o = (count_q == '0);
  assign do_pop  = pop_i && !empty_o;
  assign rec_o   = mem_q[rd_ptr_q];

  // pointer and fill level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (push_i) begin
      if (wr_ptr_q == flvd_pkg::QPtrW'(flvd_pkg::QDepth - 1)) wr_ptr_d = '0;
      else wr_ptr_d = wr_ptr_q + flvd_pkg::QPtrW'(1);
    end
    if (do_pop) begin
      if (rd_ptr_q == flvd_pkg::QPtrW'(flvd_pkg::QDepth - 1)) rd_ptr_d = '0;
      else rd_ptr_d = rd_ptr_q + flvd_pkg::QPtrW'(1);
    end
    if (push_i && !do_pop) count_d = count_q + flvd_pkg::QCntW'(1);
    else if (!push_i && do_pop) count_d = count_q - flvd_pkg::QCntW'(1);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  // record storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= rec_i;
  end

  // never written while full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("record pushed into full queue");

  // fill level stays within the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= flvd_pkg::QCntW'(flvd_pkg::QDepth))
    else $error("queue fill level beyond depth");

  // a lone push raises the fill level by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |=> count_q == $past(count_q) + flvd_pkg::QCntW'(1))
    else $error("queue fill level did not follow a push");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FLV tag deframer. A byte stream made of one
// file header and a run of tags is pushed in bursts while the result side
// stalls on its own pattern. A byte-level parser model inside the bench
// forecasts every record, and each popped record is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned StallLimit   = 5000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned TargetBytes  = 1150;
  localparam int unsigned MaxReports   = 10;
  localparam logic [15:0] PopPattern   = 16'b1011_0011_1000_1111;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        push      = 1'b0;
  logic        pop       = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        full;
  logic        empty;
  logic [1:0]  record_kind_o;
  logic [7:0]  version_o;
  logic        has_audio_o;
  logic        has_video_o;
  logic [31:0] header_length_o;
  logic [7:0]  tag_type_o;
  logic [23:0] data_size_o;
  logic [31:0] timestamp_o;
  logic [23:0] stream_id_o;
  logic [7:0]  payload_byte_o;
  logic        last_of_tag_o;

  // bytes waiting to be sent and records waiting to be popped
  logic [7:0]     stream_bytes[$];
  flvd_pkg::rec_t pending_recs[$];

  // parser model state
  flvd_pkg::phase_e prs_phase;
  logic [31:0] prs_count;
  logic [31:0] prs_shift;
  logic [7:0]  prs_type;
  logic [23:0] prs_size;
  logic [23:0] prs_time;
  logic [9:0]  prs_flags;

  int unsigned n_queued;
  int unsigned n_sent;
  int unsigned n_recs;
  int unsigned n_file;
  int unsigned n_tag;
  int unsigned n_payload;
  int unsigned n_empty_tags;
  int unsigned mismatches;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned idle_cycles;
  logic [31:0] pop_cycle;
  logic [31:0] file_hdr_len;

  flv_tag_deframer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .data_byte_i     (data_byte),
    .empty           (empty),
    .pop             (pop),
    .record_kind_o   (record_kind_o),
    .version_o       (version_o),
    .has_audio_o     (has_audio_o),
    .has_video_o     (has_video_o),
    .header_length_o (header_length_o),
    .tag_type_o      (tag_type_o),
    .data_size_o     (data_size_o),
    .timestamp_o     (timestamp_o),
    .stream_id_o     (stream_id_o),
    .payload_byte_o  (payload_byte_o),
    .last_of_tag_o   (last_of_tag_o)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // parse one accepted byte and queue the record it yields, if any
  task automatic deframe_byte(input logic [7:0] b);
    flvd_pkg::rec_t rec;
    rec = '0;
    case (prs_phase)
      flvd_pkg::PH_FILE_HDR: begin
        if (prs_count == flvd_pkg::FileVerPos) begin
          prs_flags = {b, prs_flags[1:0]};
        end else if (prs_count == flvd_pkg::FileFlagPos) begin
          prs_flags = {prs_flags[9:2], b[flvd_pkg::AudioBit], b[flvd_pkg::VideoBit]};
        end else if (prs_count >= flvd_pkg::FileLenPos) begin
          prs_shift = {prs_shift[23:0], b};
        end
        if (prs_count < flvd_pkg::FileHdrLast) begin
          prs_count = prs_count + 1;
        end else begin
          rec.kind          = flvd_pkg::KIND_FILE_HDR;
          rec.version       = prs_flags[9:2];
          rec.has_audio     = prs_flags[1];
          rec.has_video     = prs_flags[0];
          rec.header_length = prs_shift;
          pending_recs.push_back(rec);
          // a short length skips nothing
          if (prs_shift > flvd_pkg::FileHdrLen) begin
            prs_count = prs_shift - flvd_pkg::FileHdrLen;
            prs_phase = flvd_pkg::PH_SKIP;
          end else begin
            prs_count = '0;
            prs_phase = flvd_pkg::PH_PREV;
          end
          prs_shift = '0;
        end
      end
      flvd_pkg::PH_SKIP: begin
        if (prs_count != 0) prs_count = prs_count - 1;
        if (prs_count == 0) prs_phase = flvd_pkg::PH_PREV;
      end
      flvd_pkg::PH_PREV: begin
        if (prs_count < flvd_pkg::PrevSizeLast) begin
          prs_count = prs_count + 1;
        end else begin
          prs_count = '0;
          prs_shift = '0;
          prs_phase = flvd_pkg::PH_TAG_HDR;
        end
      end
      flvd_pkg::PH_TAG_HDR: begin
        if (prs_count == flvd_pkg::TagTypePos) begin
          prs_type = b;
        end else if (prs_count <= flvd_pkg::TagSizeLast) begin
          prs_size = {prs_size[15:0], b};
        end else if (prs_count <= flvd_pkg::TagTimeLast) begin
          prs_time = {prs_time[15:0], b};
        end else if (prs_count == flvd_pkg::TagExtPos) begin
          prs_flags = {2'b00, b};
        end else begin
          prs_shift = {8'h00, prs_shift[15:0], b};
        end
        if (prs_count < flvd_pkg::TagHdrLast) begin
          prs_count = prs_count + 1;
        end else begin
          rec.kind      = flvd_pkg::KIND_TAG_HDR;
          rec.tag_type  = prs_type;
          rec.data_size = prs_size;
          rec.timestamp = {prs_flags[7:0], prs_time};
          rec.stream_id = prs_shift[23:0];
          prs_shift     = '0;
          // empty payload closes the tag on its header
          if (prs_size == 0) begin
            rec.last_of_tag = 1'b1;
            prs_count       = '0;
            prs_phase       = flvd_pkg::PH_PREV;
          end else begin
            prs_count = {8'h00, prs_size};
            prs_phase = flvd_pkg::PH_PAYLOAD;
          end
          pending_recs.push_back(rec);
        end
      end
      flvd_pkg::PH_PAYLOAD: begin
        rec.kind         = flvd_pkg::KIND_PAYLOAD;
        rec.payload_byte = b;
        if (prs_count != 0) prs_count = prs_count - 1;
        if (prs_count == 0) begin
          rec.last_of_tag = 1'b1;
          prs_phase       = flvd_pkg::PH_PREV;
        end
        pending_recs.push_back(rec);
      end
      default: begin
        prs_phase = flvd_pkg::PH_PREV;
        prs_count = '0;
      end
    endcase
  endtask

  // compare the record on the ports with the oldest forecast
  task automatic check_record();
    flvd_pkg::rec_t got;
    flvd_pkg::rec_t want;
    got.kind          = flvd_pkg::rec_kind_e'(record_kind_o);
    got.version       = version_o;
    got.has_audio     = has_audio_o;
    got.has_video     = has_video_o;
    got.header_length = header_length_o;
    got.tag_type      = tag_type_o;
    got.data_size     = data_size_o;
    got.timestamp     = timestamp_o;
    got.stream_id     = stream_id_o;
    got.payload_byte  = payload_byte_o;
    got.last_of_tag   = last_of_tag_o;
    n_recs = n_recs + 1;
    if (pending_recs.size() == 0) begin
      mismatches = mismatches + 1;
      if (mismatches <= MaxReports)
        $display("[%0t] unexpected record, kind %0d", $realtime, record_kind_o);
    end else begin
      want = pending_recs.pop_front();
      case (want.kind)
        flvd_pkg::KIND_FILE_HDR: n_file = n_file + 1;
        flvd_pkg::KIND_TAG_HDR: begin
          n_tag = n_tag + 1;
          if (want.last_of_tag) n_empty_tags = n_empty_tags + 1;
        end
        default: n_payload = n_payload + 1;
      endcase
      if (got.kind !== want.kind || got.version !== want.version ||
          got.has_audio !== want.has_audio || got.has_video !== want.has_video ||
          got.header_length !== want.header_length ||
          got.tag_type !== want.tag_type || got.data_size !== want.data_size ||
          got.timestamp !== want.timestamp || got.stream_id !== want.stream_id ||
          got.payload_byte !== want.payload_byte ||
          got.last_of_tag !== want.last_of_tag) begin
        mismatches = mismatches + 1;
        if (mismatches <= MaxReports) begin
          $display("[%0t] record %0d mismatch", $realtime, n_recs);
          $display("  exp kind %0d ver %h a %b v %b hlen %h type %h size %h ts %h sid %h pay %h last %b",
                   want.kind, want.version, want.has_audio, want.has_video,
                   want.header_length, want.tag_type, want.data_size, want.timestamp,
                   want.stream_id, want.payload_byte, want.last_of_tag);
          $display("  got kind %0d ver %h a %b v %b hlen %h type %h size %h ts %h sid %h pay %h last %b",
                   got.kind, got.version, got.has_audio, got.has_video,
                   got.header_length, got.tag_type, got.data_size, got.timestamp,
                   got.stream_id, got.payload_byte, got.last_of_tag);
        end
      end
    end
  endtask

  task automatic add_byte(input logic [7:0] b);
    stream_bytes.push_back(b);
    n_queued = n_queued + 1;
  endtask

  // payload content leaning towards the all-zero and all-one bytes
  function automatic logic [7:0] payload_value();
    logic [2:0] pick;
    pick = 3'($urandom_range(0, 7));
    if (pick == 0) return 8'hFF;
    if (pick == 1) return 8'h00;
    return 8'($urandom);
  endfunction

  // previous-tag size, tag header and payload
  task automatic add_tag(input logic [7:0] ty, input logic [23:0] size,
                         input logic [31:0] ts, input logic [23:0] sid);
    int unsigned i;
    for (i = 0; i < 4; i++) add_byte(8'($urandom));
    add_byte(ty);
    add_byte(size[23:16]);
    add_byte(size[15:8]);
    add_byte(size[7:0]);
    add_byte(ts[23:16]);
    add_byte(ts[15:8]);
    add_byte(ts[7:0]);
    add_byte(ts[31:24]);
    add_byte(sid[23:16]);
    add_byte(sid[15:8]);
    add_byte(sid[7:0]);
    for (i = 0; i < size; i++) add_byte(payload_value());
  endtask

  // sender: bursts of beats with random gaps, fed from the byte queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push       <= 1'b0;
      data_byte  <= 8'h00;
      burst_left = 0;
      gap_left   = 0;
      prs_phase  = flvd_pkg::PH_FILE_HDR;
      prs_count  = '0;
      prs_shift  = '0;
      prs_type   = '0;
      prs_size   = '0;
      prs_time   = '0;
      prs_flags  = '0;
    end else begin
      if (push && !full) begin
        deframe_byte(data_byte);
        n_sent = n_sent + 1;
      end
      if (!push || !full) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          push <= 1'b0;
        end else if (stream_bytes.size() != 0) begin
          push      <= 1'b1;
          data_byte <= stream_bytes.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each popped beat and steps through four stall modes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop       <= 1'b0;
      pop_cycle = '0;
    end else begin
      if (pop && !empty) check_record();
      pop_cycle = pop_cycle + 1;
      case (pop_cycle[9:8])
        2'd0:    pop <= 1'b1;
        2'd1:    pop <= 1'($urandom_range(0, 1));
        2'd2:    pop <= ($urandom_range(0, 3) == 0);
        default: pop <= PopPattern[pop_cycle[3:0]];
      endcase
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no beat for %0d cycles, %0d records outstanding",
                 idle_cycles, pending_recs.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [7:0]  ty;
    logic [23:0] size;
    int unsigned pick;
    int unsigned i;
    n_queued     = 0;
    n_sent       = 0;
    n_recs       = 0;
    n_file       = 0;
    n_tag        = 0;
    n_payload    = 0;
    n_empty_tags = 0;
    mismatches   = 0;
    idle_cycles  = 0;

    // file header: unchecked signature, version, flags, length, skip region
    for (i = 0; i < 3; i++) add_byte(8'($urandom));
    add_byte(($urandom_range(0, 1) == 0) ? 8'hFF : 8'h01);
    add_byte(8'($urandom));
    file_hdr_len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 9) : $urandom_range(10, 40);
    add_byte(file_hdr_len[31:24]);
    add_byte(file_hdr_len[23:16]);
    add_byte(file_hdr_len[15:8]);
    add_byte(file_hdr_len[7:0]);
    if (file_hdr_len > flvd_pkg::FileHdrLen)
      for (i = 0; i < file_hdr_len - flvd_pkg::FileHdrLen; i++) add_byte(8'($urandom));

    // directed tags: back-to-back empty payloads, then extreme fields
    add_tag(8'h08, 24'd0, 32'h0000_0000, 24'h00_0000);
    add_tag(8'h00, 24'd0, $urandom, 24'($urandom));
    add_tag(8'h09, 24'd1, 32'hFFFF_FFFF, 24'hFF_FFFF);
    add_tag(8'hFF, 24'd3, 32'h8000_0001, 24'h80_0001);
    add_tag(8'h12, 24'd2, $urandom, 24'($urandom));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait until every queued byte is sent and every forecast record has been popped
    @(negedge clk_i);
    while (stream_bytes.size() != 0 || push || pending_recs.size() != 0)
      @(negedge clk_i);

    // random tags, mostly short payloads, now and then a long one
    while (n_queued < TargetBytes) begin
      pick = $urandom_range(0, 39);
      if (pick < 5) size = 24'd0;
      else if (pick == 39) size = 24'($urandom_range(256, 300));
      else size = 24'($urandom_range(1, 16));
      pick = $urandom_range(0, 3);
      if (pick == 0) ty = 8'h08;
      else if (pick == 1) ty = 8'h09;
      else ty = 8'($urandom);
      add_tag(ty, size, $urandom, 24'($urandom));
    end

    @(negedge clk_i);
    while (stream_bytes.size() != 0 || push || pending_recs.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("%0d bytes sent, %0d records popped: %0d file header, %0d tag header, %0d payload",
             n_sent, n_recs, n_file, n_tag, n_payload);
    $display("header length %0d, %0d tags with empty payload, %0d mismatches",
             file_hdr_len, n_empty_tags, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
